// File: rtl/core/iibs_pkg.sv
// Shared types, widths and codes for the integral image box-sum block.
// Used by iibs_ctrl, iibs_dpath and integral_image_box_sum; depends on nothing.
`default_nettype none

package iibs_pkg;

    // Default sizes for the top-level parameters
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_MAX_ROWS     = 128;
    localparam int DEF_MAX_COLS     = 64;
    localparam int DEF_PIXEL_BITS   = 16;

    // Fixed field and datapath widths
    localparam int SUM_W       = 29;   // table entry and box sum, unsigned Q29.0
    localparam int RSUM_W      = 22;   // running row sum
    localparam int CH_IN_W     = 3;
    localparam int ROW_IN_W    = 7;
    localparam int COL_IN_W    = 6;
    localparam int ROW_Q_W     = ROW_IN_W + 1;   // row after pin offset
    localparam int COL_Q_W     = COL_IN_W + 1;   // column after pin offset
    localparam int ROWS_CFG_W  = 8;
    localparam int COLS_CFG_W  = 7;
    localparam int CHANS_CFG_W = 4;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int LIM_W       = 11;   // wide enough for any size limit

    // Register reset values before clamping
    localparam logic [ROWS_CFG_W-1:0] RST_ROWS  = 8'd128;
    localparam logic [ROWS_CFG_W-1:0] RST_COLS  = 8'd64;
    localparam logic [ROWS_CFG_W-1:0] RST_CHANS = 8'd8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_ROWS = 2'd0,
        CFG_IMAGE_COLS = 2'd1,
        CFG_CHANNELS   = 2'd2
    } cfg_index_t;

    // Item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_item;   // register the accepted item
        logic rd_load;     // read the entry above the load position
        logic load_wr;     // write the new table entry and advance
        logic rd_q0;       // read corners (r1,c1) and (r0-1,c1)
        logic rd_q1;       // read corners (r1,c0-1) and (r0-1,c0-1)
        logic out_load;    // load the result register
    } iibs_cmd_t;

    // Clamp a register value to 1..hi
    function automatic logic [ROWS_CFG_W-1:0] clamp_cfg(
        input logic [ROWS_CFG_W-1:0] v,
        input logic [LIM_W-1:0]      hi
    );
        logic [ROWS_CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = 8'd1;
        end else if (LIM_W'(v) > hi) begin
            r = hi[ROWS_CFG_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/iibs_ctrl.sv
// Controller for the integral image box-sum block: item sequencing and result handshake.
// Depends on iibs_pkg (command struct, mode codes).
`default_nettype none

module iibs_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_mode,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output iibs_pkg::iibs_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_WR,
        S_Q_RD0,
        S_Q_RD1,
        S_Q_SUM
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   take;

    assign out_free = !m_valid_reg || m_ready;
    assign take     = (state_reg == S_IDLE) && s_valid && s_ready_reg;

    // Next state and result-valid
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    state_next = (s_mode == iibs_pkg::MODE_QUERY) ? S_Q_RD0 : S_LD_WR;
                end
            end
            S_LD_WR: state_next = S_IDLE;
            S_Q_RD0: state_next = S_Q_RD1;
            S_Q_RD1: state_next = S_Q_SUM;
            S_Q_SUM: begin
                // hold until the result register is free
                if (out_free) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == S_IDLE);
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath commands
    always_comb begin
        cmd.take_item = take;
        cmd.rd_load   = (state_reg == S_IDLE);
        cmd.load_wr   = (state_reg == S_LD_WR);
        cmd.rd_q0     = (state_reg == S_Q_RD0);
        cmd.rd_q1     = (state_reg == S_Q_RD1);
        cmd.out_load  = (state_reg == S_Q_SUM) && out_free;
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

    // A load transfer goes straight to the table write
    a_load_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_mode == iibs_pkg::MODE_LOAD) |=> state_reg == S_LD_WR)
        else $error("load did not move to the write state");

    // A query transfer walks both read states before summing
    a_query_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_mode == iibs_pkg::MODE_QUERY)
            |=> state_reg == S_Q_RD0 ##1 state_reg == S_Q_RD1 ##1 state_reg == S_Q_SUM)
        else $error("query read sequence broken");

    // Only a finished query raises the result valid
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_Q_SUM)
        else $error("result valid raised outside the sum state");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while still held");

endmodule

`default_nettype wire

// File: rtl/core/iibs_dpath.sv
// Datapath for the integral image box-sum block: configuration registers, load
// position, summed-area store and corner arithmetic. Depends on iibs_pkg.
`default_nettype none

module iibs_dpath #(
    parameter int MAX_CHANNELS = iibs_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_ROWS     = iibs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS     = iibs_pkg::DEF_MAX_COLS,
    parameter int PIXEL_BITS   = iibs_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire iibs_pkg::iibs_cmd_t             cmd,
    input  wire logic                            cfg_wr_en,
    input  wire logic [iibs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [iibs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [PIXEL_BITS-1:0]           s_pixel_value,
    input  wire logic [iibs_pkg::CH_IN_W-1:0]    s_channel,
    input  wire logic [iibs_pkg::ROW_IN_W-1:0]   s_top_row,
    input  wire logic [iibs_pkg::COL_IN_W-1:0]   s_left_col,
    input  wire logic [iibs_pkg::ROW_IN_W-1:0]   s_bottom_row,
    input  wire logic [iibs_pkg::COL_IN_W-1:0]   s_right_col,
    input  wire logic [iibs_pkg::ROW_IN_W-1:0]   s_pin_row,
    input  wire logic [iibs_pkg::COL_IN_W-1:0]   s_pin_col,
    output logic [iibs_pkg::SUM_W-1:0]           m_rect_sum,
    output logic                                 m_status
);

    localparam int SW     = iibs_pkg::SUM_W;
    localparam int RW     = iibs_pkg::RSUM_W;
    localparam int LW     = iibs_pkg::LIM_W;
    localparam int RQW    = iibs_pkg::ROW_Q_W;
    localparam int CQW    = iibs_pkg::COL_Q_W;
    localparam int RCW    = iibs_pkg::ROWS_CFG_W;
    localparam int CCW    = iibs_pkg::COLS_CFG_W;
    localparam int HCW    = iibs_pkg::CHANS_CFG_W;
    localparam int CHW    = iibs_pkg::CH_IN_W;
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ADDR_W = CH_W + ROW_W + COL_W;
    localparam int DEPTH  = 1 << ADDR_W;

    localparam logic [RCW-1:0] ROWS_RST =
        iibs_pkg::clamp_cfg(iibs_pkg::RST_ROWS, LW'(MAX_ROWS));
    localparam logic [RCW-1:0] COLS_RST =
        iibs_pkg::clamp_cfg(iibs_pkg::RST_COLS, LW'(MAX_COLS));
    localparam logic [RCW-1:0] CHANS_RST =
        iibs_pkg::clamp_cfg(iibs_pkg::RST_CHANS, LW'(MAX_CHANNELS));

    // Configuration, already clamped to 1..MAX
    logic [RCW-1:0] rows_reg;
    logic [CCW-1:0] cols_reg;
    logic [HCW-1:0] chans_reg;

    // Load position and running row sum
    logic [CH_W-1:0]  ld_ch_reg;
    logic [ROW_W-1:0] ld_row_reg;
    logic [COL_W-1:0] ld_col_reg;
    logic [RW-1:0]    rsum_reg;

    // Accepted item
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [CHW-1:0]        qch_reg;
    logic [RQW-1:0]        r0_reg, r1_reg;
    logic [CQW-1:0]        c0_reg, c1_reg;

    // Query state
    logic          reject_reg, rn_reg, cn_reg;
    logic [SW-1:0] rd_a_reg, rd_b_reg, ab_reg;
    logic [SW-1:0] sum_reg;
    logic          status_reg;

    // Summed-area store
    logic [SW-1:0] sat_mem [DEPTH];

    logic              cfg_hit;
    logic [RW-1:0]     rsum_base, rsum_next;
    logic [SW-1:0]     above, entry;
    logic [LW-1:0]     col_inc, row_inc, ch_inc;
    logic [ADDR_W-1:0] wr_addr, ld_above_addr, addr_a, addr_b;
    logic [CH_W-1:0]   q_ch;
    logic [ROW_W-1:0]  q_r1, q_r0m1;
    logic [COL_W-1:0]  q_c1, q_c0m1;
    logic [RQW-1:0]    r0m1;
    logic [CQW-1:0]    c0m1;
    logic [SW-1:0]     sum_calc;

    // Load entry: running row sum plus the entry above
    assign rsum_base = (ld_col_reg == '0) ? '0 : rsum_reg;
    assign rsum_next = rsum_base + RW'(pix_reg);
    assign above     = (ld_row_reg == '0) ? '0 : rd_a_reg;
    assign entry     = above + SW'(rsum_next);

    assign col_inc = LW'(ld_col_reg) + LW'(1);
    assign row_inc = LW'(ld_row_reg) + LW'(1);
    assign ch_inc  = LW'(ld_ch_reg) + LW'(1);

    assign wr_addr       = {ld_ch_reg, ld_row_reg, ld_col_reg};
    assign ld_above_addr = {ld_ch_reg, ld_row_reg - ROW_W'(1), ld_col_reg};

    // Corner addresses
    assign r0m1   = r0_reg - RQW'(1);
    assign c0m1   = c0_reg - CQW'(1);
    assign q_ch   = CH_W'(qch_reg);
    assign q_r1   = ROW_W'(r1_reg);
    assign q_r0m1 = ROW_W'(r0m1);
    assign q_c1   = COL_W'(c1_reg);
    assign q_c0m1 = COL_W'(c0m1);

    always_comb begin
        if (cmd.rd_q0) begin
            addr_a = {q_ch, q_r1, q_c1};
            addr_b = {q_ch, q_r0m1, q_c1};
        end else if (cmd.rd_q1) begin
            addr_a = {q_ch, q_r1, q_c0m1};
            addr_b = {q_ch, q_r0m1, q_c0m1};
        end else begin
            addr_a = ld_above_addr;
            addr_b = {q_ch, q_r0m1, q_c0m1};
        end
    end

    // Store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (cmd.load_wr) begin
            sat_mem[wr_addr] <= entry;
        end
        if (cmd.rd_load || cmd.rd_q0 || cmd.rd_q1) begin
            rd_a_reg <= sat_mem[addr_a];
        end
        if (cmd.rd_q0 || cmd.rd_q1) begin
            rd_b_reg <= sat_mem[addr_b];
        end
    end

    // Config writes and load position; a write to any of the three restarts loading
    assign cfg_hit = cfg_wr_en && (cfg_index == iibs_pkg::CFG_IMAGE_ROWS ||
                                   cfg_index == iibs_pkg::CFG_IMAGE_COLS ||
                                   cfg_index == iibs_pkg::CFG_CHANNELS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg   <= ROWS_RST;
            cols_reg   <= CCW'(COLS_RST);
            chans_reg  <= HCW'(CHANS_RST);
            ld_ch_reg  <= '0;
            ld_row_reg <= '0;
            ld_col_reg <= '0;
            rsum_reg   <= '0;
        end else if (cfg_hit) begin
            unique case (cfg_index)
                iibs_pkg::CFG_IMAGE_ROWS:
                    rows_reg <= iibs_pkg::clamp_cfg(cfg_wdata, LW'(MAX_ROWS));
                iibs_pkg::CFG_IMAGE_COLS:
                    cols_reg <= CCW'(iibs_pkg::clamp_cfg(RCW'(cfg_wdata[CCW-1:0]),
                                                         LW'(MAX_COLS)));
                default:
                    chans_reg <= HCW'(iibs_pkg::clamp_cfg(RCW'(cfg_wdata[HCW-1:0]),
                                                          LW'(MAX_CHANNELS)));
            endcase
            ld_ch_reg  <= '0;
            ld_row_reg <= '0;
            ld_col_reg <= '0;
            rsum_reg   <= '0;
        end else if (cmd.load_wr) begin
            // advance column, then row, then channel
            rsum_reg <= rsum_next;
            if (col_inc >= LW'(cols_reg)) begin
                ld_col_reg <= '0;
                if (row_inc >= LW'(rows_reg)) begin
                    ld_row_reg <= '0;
                    if (ch_inc >= LW'(chans_reg)) begin
                        ld_ch_reg <= '0;
                    end else begin
                        ld_ch_reg <= CH_W'(ch_inc);
                    end
                end else begin
                    ld_row_reg <= ROW_W'(row_inc);
                end
            end else begin
                ld_col_reg <= COL_W'(col_inc);
            end
        end
    end

    // Capture the item and add the pin offsets
    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            pix_reg <= s_pixel_value;
            qch_reg <= s_channel;
            r0_reg  <= RQW'(s_top_row) + RQW'(s_pin_row);
            r1_reg  <= RQW'(s_bottom_row) + RQW'(s_pin_row);
            c0_reg  <= CQW'(s_left_col) + CQW'(s_pin_col);
            c1_reg  <= CQW'(s_right_col) + CQW'(s_pin_col);
        end
    end

    // Range checks, then the first partial difference
    always_ff @(posedge aclk) begin
        if (cmd.rd_q0) begin
            reject_reg <= (HCW'(qch_reg) >= chans_reg) || (r0_reg > r1_reg) ||
                          (c0_reg > c1_reg) || (r1_reg >= rows_reg) ||
                          (c1_reg >= cols_reg);
            rn_reg     <= (r0_reg == '0);
            cn_reg     <= (c0_reg == '0);
        end
        if (cmd.rd_q1) begin
            ab_reg <= rd_a_reg - (rn_reg ? '0 : rd_b_reg);
        end
    end

    // Finish the four-corner sum into the result register
    assign sum_calc = ab_reg - (cn_reg ? '0 : rd_a_reg) +
                      ((rn_reg || cn_reg) ? '0 : rd_b_reg);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            sum_reg    <= reject_reg ? '0 : sum_calc;
            status_reg <= reject_reg;
        end
    end

    assign m_rect_sum = sum_reg;
    assign m_status   = status_reg;

endmodule

`default_nettype wire

// File: rtl/core/integral_image_box_sum.sv
// Top level of the integral image box-sum block: ports, controller and datapath.
// Depends on iibs_pkg, iibs_ctrl and iibs_dpath.
`default_nettype none

// Builds a summed-area table per channel from streamed pixels (mode 0, channel by
// channel in raster order) and answers rectangle queries (mode 1) with the
// four-corner box sum after adding the pin offset. A load reads the entry above
// while the block waits for the transfer, then writes the new entry. A query
// reads two corners at a time through the two read ports of the store, in the
// states S_Q_RD0 and S_Q_RD1, then finishes the sum in S_Q_SUM, where it waits
// if the previous result has not been taken. A rejected rectangle (inverted,
// outside the image, or a channel not in use) returns status 1 and a sum of 0.
// Queries must only touch entries already loaded; the store has no reset.
// A rows, cols or channels write restarts loading at channel 0, row 0, column 0.
module integral_image_box_sum #(
    parameter int MAX_CHANNELS = iibs_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_ROWS     = iibs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS     = iibs_pkg::DEF_MAX_COLS,
    parameter int PIXEL_BITS   = iibs_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [iibs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [iibs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_mode,
    input  wire logic [PIXEL_BITS-1:0]           s_pixel_value,
    input  wire logic [iibs_pkg::CH_IN_W-1:0]    s_channel,
    input  wire logic [iibs_pkg::ROW_IN_W-1:0]   s_top_row,
    input  wire logic [iibs_pkg::COL_IN_W-1:0]   s_left_col,
    input  wire logic [iibs_pkg::ROW_IN_W-1:0]   s_bottom_row,
    input  wire logic [iibs_pkg::COL_IN_W-1:0]   s_right_col,
    input  wire logic [iibs_pkg::ROW_IN_W-1:0]   s_pin_row,
    input  wire logic [iibs_pkg::COL_IN_W-1:0]   s_pin_col,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [iibs_pkg::SUM_W-1:0]           m_rect_sum,
    output logic                                 m_status
);

    iibs_pkg::iibs_cmd_t cmd;

    // Sequencing and handshakes
    iibs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Table store and arithmetic
    iibs_dpath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .PIXEL_BITS   (PIXEL_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_pixel_value (s_pixel_value),
        .s_channel     (s_channel),
        .s_top_row     (s_top_row),
        .s_left_col    (s_left_col),
        .s_bottom_row  (s_bottom_row),
        .s_right_col   (s_right_col),
        .s_pin_row     (s_pin_row),
        .s_pin_col     (s_pin_col),
        .m_rect_sum    (m_rect_sum),
        .m_status      (m_status)
    );

endmodule

`default_nettype wire
